// ===== src/fli_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the field line interpolator.
// No dependencies; imported by fli_ctrl and field_line_interpolator_core.
package fli_pkg;

    localparam int unsigned SAMPLE_W     = 8;
    localparam int unsigned COL_W        = 13;
    localparam int unsigned ROW_W        = 11;
    localparam int unsigned ROW_BYTES_W  = 14;
    localparam int unsigned FIELD_ROWS_W = 12;
    localparam int unsigned CFG_DATA_W   = 14;
    localparam int unsigned CFG_ADDR_W   = 1;

    localparam logic [ROW_BYTES_W-1:0]  ROW_BYTES_RST  = ROW_BYTES_W'(7680);
    localparam logic [FIELD_ROWS_W-1:0] FIELD_ROWS_RST = FIELD_ROWS_W'(540);

    localparam logic [CFG_ADDR_W-1:0] CFG_ROW_BYTES  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIELD_ROWS = 1'b1;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             first_row;
        logic             end_row;
        logic             end_field;
    } t_pos;

endpackage

// ===== src/fli_line_store.sv =====
`timescale 1ns / 1ps
// Line store: single-port synchronous RAM with one address for read and write, read-first.
// No package dependencies.
module fli_line_store #(
    parameter int unsigned DEPTH = 8192,
    parameter int unsigned AW    = 13,
    parameter int unsigned DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata        <= r_mem[i_addr];
            r_mem[i_addr]  <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/fli_ctrl.sv =====
`timescale 1ns / 1ps
// Configuration registers and raster position counters.
// Depends on fli_pkg.
module fli_ctrl #(
    parameter int unsigned MAX_ROW_BYTES  = 8192,
    parameter int unsigned MAX_FIELD_ROWS = 2048
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fli_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [fli_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_advance,
    output fli_pkg::t_pos                   o_pos
);
    import fli_pkg::*;

    localparam int unsigned WW = ($clog2(MAX_ROW_BYTES + 1) > ROW_BYTES_W) ?
                                 $clog2(MAX_ROW_BYTES + 1) : ROW_BYTES_W;
    localparam int unsigned HW = ($clog2(MAX_FIELD_ROWS + 1) > FIELD_ROWS_W) ?
                                 $clog2(MAX_FIELD_ROWS + 1) : FIELD_ROWS_W;

    logic [ROW_BYTES_W-1:0]  r_row_bytes;
    logic [FIELD_ROWS_W-1:0] r_field_rows;
    logic [COL_W-1:0]        r_col, n_col;
    logic [ROW_W-1:0]        r_row, n_row;

    logic [WW-1:0] w_eff, w_m1;
    logic [HW-1:0] h_eff, h_m1;
    logic          end_row, end_field;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes  <= ROW_BYTES_RST;
            r_field_rows <= FIELD_ROWS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ROW_BYTES:  r_row_bytes  <= i_cfg_wdata[ROW_BYTES_W-1:0];
                CFG_FIELD_ROWS: r_field_rows <= i_cfg_wdata[FIELD_ROWS_W-1:0];
            endcase
        end
    end

    // clamp the registers to the supported frame size
    always_comb begin
        if (r_row_bytes == '0)
            w_eff = WW'(1);
        else if (WW'(r_row_bytes) > WW'(MAX_ROW_BYTES))
            w_eff = WW'(MAX_ROW_BYTES);
        else
            w_eff = WW'(r_row_bytes);
        w_m1 = w_eff - WW'(1);

        if (HW'(r_field_rows) < HW'(2))
            h_eff = HW'(2);
        else if (HW'(r_field_rows) > HW'(MAX_FIELD_ROWS))
            h_eff = HW'(MAX_FIELD_ROWS);
        else
            h_eff = HW'(r_field_rows);
        h_m1 = h_eff - HW'(1);
    end

    assign end_row   = (WW'(r_col) >= w_m1);
    assign end_field = (HW'(r_row) >= h_m1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_advance) begin
            if (end_row) begin
                n_col = '0;
                n_row = end_field ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_pos.row       = r_row;
    assign o_pos.col       = r_col;
    assign o_pos.first_row = (r_row == '0);
    assign o_pos.end_row   = end_row;
    assign o_pos.end_field = end_field;

endmodule

// ===== src/field_line_interpolator_core.sv =====
`timescale 1ns / 1ps
// Top level of the field line interpolator: handshake pipeline around the line store.
// Depends on fli_pkg, fli_ctrl and fli_line_store.

// Takes one byte per clock while o_ready is high and, from the second row of the field
// on, returns one pair per byte: the byte above from the line store and the sum of the
// halved byte above and halved new byte. Row 0 only loads the store. A byte passes the
// stage 1 register, then the output register, which stalls while i_ready is low. The
// line store is read and written once per accepted byte. The store is not cleared at
// reset: growing row_bytes between rows reads entries that were never written, and
// those kept bytes are undefined. Write configuration only while the block is idle.
module field_line_interpolator_core #(
    parameter int unsigned MAX_ROW_BYTES  = 8192,
    parameter int unsigned MAX_FIELD_ROWS = 2048
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fli_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [fli_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [fli_pkg::SAMPLE_W-1:0]    i_sample,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [fli_pkg::SAMPLE_W-1:0]    o_kept_byte,
    output logic [fli_pkg::SAMPLE_W-1:0]    o_interpolated_byte,
    output logic [fli_pkg::ROW_W-1:0]       o_pair_row,
    output logic [fli_pkg::COL_W-1:0]       o_column,
    output logic                            o_last_of_field
);
    import fli_pkg::*;

    localparam int unsigned AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

    t_pos                pos;
    logic                accept;
    logic                out_free;
    logic                s1_go;
    logic [SAMPLE_W-1:0] above;
    logic [AW-1:0]       addr;

    logic                r_s1_valid;
    logic                r_s1_has;
    logic [SAMPLE_W-1:0] r_s1_cur;
    logic [ROW_W-1:0]    r_s1_row;
    logic [COL_W-1:0]    r_s1_col;
    logic                r_s1_last;

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_kept;
    logic [SAMPLE_W-1:0] r_interp;
    logic [ROW_W-1:0]    r_pair_row;
    logic [COL_W-1:0]    r_col;
    logic                r_last;

    assign out_free = !r_out_valid || i_ready;
    assign s1_go    = !r_s1_has || out_free;
    assign o_ready  = !r_s1_valid || s1_go;
    assign accept   = i_valid && o_ready;
    assign addr     = AW'(pos.col);

    fli_ctrl #(
        .MAX_ROW_BYTES  (MAX_ROW_BYTES),
        .MAX_FIELD_ROWS (MAX_FIELD_ROWS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_advance   (accept),
        .o_pos       (pos)
    );

    fli_line_store #(
        .DEPTH (MAX_ROW_BYTES),
        .AW    (AW),
        .DW    (SAMPLE_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (accept),
        .i_addr  (addr),
        .i_wdata (i_sample),
        .o_rdata (above)
    );

    // stage 1: wait for the line store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_has  <= !pos.first_row;
            r_s1_cur  <= i_sample;
            r_s1_row  <= pos.row - ROW_W'(1);
            r_s1_col  <= pos.col;
            r_s1_last <= pos.end_row && pos.end_field;
        end
    end

    // output register: load on a stage 1 item that carries a pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s1_valid && r_s1_has && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && r_s1_has && out_free) begin
            r_kept     <= above;
            r_interp   <= (above >> 1) + (r_s1_cur >> 1);
            r_pair_row <= r_s1_row;
            r_col      <= r_s1_col;
            r_last     <= r_s1_last;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_kept_byte         = r_kept;
    assign o_interpolated_byte = r_interp;
    assign o_pair_row          = r_pair_row;
    assign o_column            = r_col;
    assign o_last_of_field     = r_last;

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("transfer did not reach stage 1");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_has && !out_free && !accept) |=>
            (r_s1_valid && $stable(r_s1_col) && $stable(r_s1_row)))
        else $error("stalled stage 1 pair lost");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(pos.col) < MAX_ROW_BYTES))
        else $error("column counter beyond line store");

    a_row0_no_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && pos.first_row) |=> !r_s1_has)
        else $error("first row produced a pair");

endmodule
